@@ rtl/jsu_pkg.sv @@
`default_nettype none

package jsu_pkg;

  // result status codes
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_CLOSED = 3'd1;
  localparam logic [2:0] ST_NOOPEN = 3'd2;
  localparam logic [2:0] ST_BADESC = 3'd3;
  localparam logic [2:0] ST_BADHEX = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  // utf-8 encoding limits and marks
  localparam logic [15:0] UTF_MAX1 = 16'h007f;
  localparam logic [15:0] UTF_MAX2 = 16'h07ff;
  localparam logic [7:0] UTF_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF_LEAD3 = 8'he0;
  localparam logic [7:0] UTF_CONT = 8'h80;
  localparam logic [7:0] UTF_CONT_MASK = 8'h3f;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one classified input byte: up to three results
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0] count;
    logic [2:0] status;
  } entry_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/jsu_front.sv @@
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] data_byte,
  input  wire logic       start_req,
  output logic            in_ready,
  input  wire logic       full,
  output logic            push,
  output entry_t          push_entry
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_BODY = 3'd1;
  localparam logic [2:0] M_ESC  = 3'd2;
  localparam logic [2:0] M_HEX  = 3'd3;
  localparam logic [2:0] M_HALT = 3'd4;

  logic [2:0] mode, mode_next;
  logic [15:0] hex_value, hex_value_next;
  logic [1:0] hex_count, hex_count_next;
  logic accept;
  logic [4:0] hd;
  logic [15:0] cp;
  entry_t e;

  assign in_ready = !full;
  assign accept = in_valid && !full;
  assign hd = hex_digit(data_byte);
  assign cp = {hex_value[11:0], hd[3:0]};

  // classify the byte and step the parser
  always_comb begin
    mode_next = mode;
    hex_value_next = hex_value;
    hex_count_next = hex_count;
    e = '0;
    if (start_req) begin
      hex_value_next = '0;
      hex_count_next = '0;
      if (data_byte == CH_QUOTE) begin
        mode_next = M_BODY;
      end else begin
        mode_next = M_HALT;
        e.count = 2'd1;
        e.status = ST_NOOPEN;
      end
    end else begin
      unique case (mode)
        M_BODY: begin
          if (data_byte == CH_QUOTE) begin
            mode_next = M_HALT;
            e.count = 2'd1;
            e.status = ST_CLOSED;
          end else if (data_byte == CH_BSLASH) begin
            mode_next = M_ESC;
          end else begin
            e.count = 2'd1;
            e.bytes[0] = data_byte;
          end
        end
        M_ESC: begin
          mode_next = M_BODY;
          e.count = 2'd1;
          case (data_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: e.bytes[0] = data_byte;
            CH_B: e.bytes[0] = 8'h08;
            CH_F: e.bytes[0] = 8'h0c;
            CH_N: e.bytes[0] = 8'h0a;
            CH_R: e.bytes[0] = 8'h0d;
            CH_T: e.bytes[0] = 8'h09;
            CH_U: begin
              mode_next = M_HEX;
              hex_value_next = '0;
              hex_count_next = '0;
              e.count = 2'd0;
            end
            default: begin
              mode_next = M_HALT;
              e.status = ST_BADESC;
            end
          endcase
        end
        M_HEX: begin
          if (!hd[4]) begin
            mode_next = M_HALT;
            e.count = 2'd1;
            e.status = ST_BADHEX;
          end else begin
            hex_value_next = cp;
            if (hex_count == 2'd3) begin
              hex_count_next = '0;
              mode_next = M_BODY;
              // encode the code point
              if (cp <= UTF_MAX1) begin
                e.count = 2'd1;
                e.bytes[0] = cp[7:0];
              end else if (cp <= UTF_MAX2) begin
                e.count = 2'd2;
                e.bytes[0] = UTF_LEAD2 | {3'b0, cp[10:6]};
                e.bytes[1] = UTF_CONT | (cp[7:0] & UTF_CONT_MASK);
              end else begin
                e.count = 2'd3;
                e.bytes[0] = UTF_LEAD3 | {4'b0, cp[15:12]};
                e.bytes[1] = UTF_CONT | ({2'b0, cp[11:6]} & UTF_CONT_MASK);
                e.bytes[2] = UTF_CONT | (cp[7:0] & UTF_CONT_MASK);
              end
            end else begin
              hex_count_next = hex_count + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push = accept && (e.count != 2'd0);
  assign push_entry = e;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      hex_value <= '0;
      hex_count <= '0;
    end else if (accept) begin
      mode <= mode_next;
      hex_value <= hex_value_next;
      hex_count <= hex_count_next;
    end
  end

  // any error or close ends the string
  a_halt_after_status: assert property (@(posedge clk) disable iff (rst)
    push && (e.status != ST_DATA) |=> mode == M_HALT)
    else $error("front did not halt after status result");

endmodule

`default_nettype wire

@@ rtl/jsu_queue.sv @@
`default_nettype none

module jsu_queue import jsu_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  entry_t      push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output logic        empty,
  output logic        full
);

  entry_t slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full = (fill == QCNT_W'(QDEPTH));
  assign head = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue underflow");

endmodule

`default_nettype wire

@@ rtl/jsu_back.sv @@
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  entry_t          head,
  input  wire logic       empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [2:0]      status,
  output logic            last
);

  logic [1:0] idx;
  logic load;
  logic is_last;

  assign load = (!out_valid || out_ready) && !empty;
  assign is_last = (idx == head.count - 2'd1);
  assign pop = load && is_last;

  // result counter within the current entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.bytes[idx];
      status <= head.status;
      last <= is_last;
    end
  end

  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx < head.count)
    else $error("result index past entry");

endmodule

`default_nettype wire

@@ rtl/json_string_unescaper_unit.sv @@
// channel   dir  tdata                        tuser        tlast
// s_axis    in   [7:0] data_byte              [0] start    -
// m_axis    out  [7:0] out_byte,[10:8] status -            last
//
// an input byte is taken every cycle while the two-entry queue has room;
// a byte giving one result keeps one byte per cycle end to end with a steady output.
// a \u escape that ends in a two or three byte sequence holds the output
// register for one result per byte; with bytes following back to back and
// a steady output, s_axis stalls while it drains.
// results pass a queue slot, then the output register; reset clears parser and queue.
// m_axis_tready low stalls the output register, then the queue, then s_axis.

`default_nettype none

module json_string_unescaper_unit import jsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] start_req
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] status, rest zero
  output logic             m_axis_tlast
);

  logic push, pop, empty, full;
  entry_t push_entry, head;
  logic [7:0] out_byte;
  logic [2:0] status;

  jsu_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .data_byte(s_axis_tdata), .start_req(s_axis_tuser),
    .in_ready(s_axis_tready), .full(full),
    .push(push), .push_entry(push_entry)
  );

  jsu_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_entry(push_entry),
    .pop(pop), .head(head), .empty(empty), .full(full)
  );

  jsu_back u_back (
    .clk(clk), .rst(rst),
    .head(head), .empty(empty), .pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_byte(out_byte), .status(status), .last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, status, out_byte};

endmodule

`default_nettype wire

@@ verif/json_string_unescaper_checker.sv @@
`default_nettype none

module json_string_unescaper_checker
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] start_req
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, rest zero
  input  wire logic        m_axis_tlast,
  output int               fail_count,
  output int               pending,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {P_IDLE, P_BODY, P_ESC, P_HEX, P_HALT} parse_mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } dec_result_t;

  // decoder state as the block should hold it
  parse_mode_t mode;
  logic [15:0] code_point;
  logic [1:0]  digit_cnt;

  dec_result_t decoded_q[$];
  int          fails;
  int          n_checked;

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    fails = 0;
    n_checked = 0;
    mode = P_IDLE;
    code_point = '0;
    digit_cnt = '0;
  end

  // hex character to {ok, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'b0;
  endfunction

  // advance the decoder by one accepted byte and queue what it yields
  task automatic decode_byte(input logic [7:0] c, input logic start);
    logic [7:0]  ob [3];
    logic [2:0]  os [3];
    logic [4:0]  nib;
    dec_result_t r;
    int          n;
    n = 0;
    for (int k = 0; k < 3; k++) begin
      ob[k] = 8'h00;
      os[k] = ST_DATA;
    end
    if (start) begin
      code_point = '0;
      digit_cnt = '0;
      if (c == CH_QUOTE) begin
        mode = P_BODY;
      end else begin
        mode = P_HALT;
        os[0] = ST_NOOPEN;
        n = 1;
      end
    end else begin
      case (mode)
        P_BODY: begin
          if (c == CH_QUOTE) begin
            mode = P_HALT;
            os[0] = ST_CLOSED;
            n = 1;
          end else if (c == CH_BSLASH) begin
            mode = P_ESC;
          end else begin
            ob[0] = c;
            n = 1;
          end
        end
        P_ESC: begin
          mode = P_BODY;
          n = 1;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: ob[0] = c;
            CH_B: ob[0] = 8'h08;
            CH_F: ob[0] = 8'h0c;
            CH_N: ob[0] = 8'h0a;
            CH_R: ob[0] = 8'h0d;
            CH_T: ob[0] = 8'h09;
            CH_U: begin
              mode = P_HEX;
              code_point = '0;
              digit_cnt = '0;
              n = 0;
            end
            default: begin
              mode = P_HALT;
              os[0] = ST_BADESC;
            end
          endcase
        end
        P_HEX: begin
          nib = hex_nibble(c);
          if (!nib[4]) begin
            mode = P_HALT;
            os[0] = ST_BADHEX;
            n = 1;
          end else begin
            code_point = {code_point[11:0], nib[3:0]};
            if (digit_cnt == 2'd3) begin
              digit_cnt = '0;
              mode = P_BODY;
              // utf-8 encoding, one to three bytes
              if (code_point <= UTF_MAX1) begin
                ob[0] = code_point[7:0];
                n = 1;
              end else if (code_point <= UTF_MAX2) begin
                ob[0] = UTF_LEAD2 | {3'b0, code_point[10:6]};
                ob[1] = UTF_CONT | {2'b0, code_point[5:0]};
                n = 2;
              end else begin
                ob[0] = UTF_LEAD3 | {4'b0, code_point[15:12]};
                ob[1] = UTF_CONT | {2'b0, code_point[11:6]};
                ob[2] = UTF_CONT | {2'b0, code_point[5:0]};
                n = 3;
              end
            end else begin
              digit_cnt = digit_cnt + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
    for (int k = 0; k < n; k++) begin
      r.out_byte = ob[k];
      r.status = os[k];
      r.last = (k == n - 1);
      decoded_q.insert(decoded_q.size(), r);
    end
  endtask

  task automatic note_fail(input string msg);
    fails++;
    if (fails <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // requests in, results out, both sampled at the clock edge
  always @(posedge clk) begin
    dec_result_t want;
    if (rst) begin
      mode = P_IDLE;
      code_point = '0;
      digit_cnt = '0;
      decoded_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          note_fail($sformatf("unexpected result tdata %04h last %0b",
                              m_axis_tdata, m_axis_tlast));
        end else begin
          want = decoded_q.pop_front();
          n_checked++;
          if (m_axis_tdata[7:0] !== want.out_byte || m_axis_tdata[10:8] !== want.status ||
              m_axis_tdata[15:11] !== 5'b0 || m_axis_tlast !== want.last) begin
            note_fail($sformatf({"result %0d mismatch: expected byte %02h status %0d ",
                                 "last %0b, got tdata %04h last %0b"},
                                n_checked, want.out_byte, want.status, want.last,
                                m_axis_tdata, m_axis_tlast));
          end
        end
      end
    end
    fail_count <= fails;
    pending <= decoded_q.size();
    checked <= n_checked;
  end

endmodule

`default_nettype wire

@@ verif/tb_json_string_unescaper_unit.sv @@
`default_nettype none

module tb_json_string_unescaper_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam int ITEMS        = 330;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int N_DIRECTED   = 28;

  localparam logic [7:0] ESC_LETTERS [8] =
    '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
  localparam logic [15:0] CP_EDGES [6] =
    '{16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hffff};

  // directed bytes as {start, byte}
  localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
    {1'b0, CH_QUOTE},                                      // before any start
    {1'b1, CH_QUOTE}, {1'b0, 8'h00}, {1'b0, 8'hff},
    {1'b0, CH_BSLASH}, {1'b0, CH_N},
    // \u07fF, two byte sequence
    {1'b0, CH_BSLASH}, {1'b0, CH_U}, {1'b0, 8'h30}, {1'b0, 8'h37},
    {1'b0, 8'h66}, {1'b0, 8'h46},
    // \uFfa then restart in the middle of the escape
    {1'b0, CH_BSLASH}, {1'b0, CH_U}, {1'b0, 8'h46}, {1'b0, 8'h66}, {1'b0, 8'h61},
    {1'b1, CH_QUOTE},
    {1'b0, CH_QUOTE}, {1'b0, 8'h78},                       // close, then ignored byte
    {1'b1, 8'h00},                                         // bad opening
    {1'b1, CH_QUOTE}, {1'b0, CH_BSLASH}, {1'b0, 8'h71},    // bad escape letter
    {1'b1, CH_QUOTE}, {1'b0, CH_BSLASH}, {1'b0, CH_U}, {1'b0, 8'h47}  // bad hex digit
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;    // [0] start_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [10:8] status, rest zero
  logic        m_axis_tlast;

  int   fail_count;
  int   pending;
  int   checked;
  int   sent_items = 0;
  int   strings_sent = 0;
  int   send_idle_pct = 10;
  int   recv_idle_pct = 59;
  logic hold_rx = 1'b0;

  json_string_unescaper_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  json_string_unescaper_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    wait (sent_items >= 80);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return 8'h30 + {4'b0, v};
    return (upper ? 8'h37 : 8'h57) + {4'b0, v};
  endfunction

  // offer one request and wait for it to be taken
  task automatic push_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_items++;
    if (start) strings_sent++;
  endtask

  task automatic push_noise(input int count);
    repeat (count) push_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic push_hex(input logic [3:0] v);
    push_byte(hex_char(v, 1'($urandom_range(1))), 1'b0);
  endtask

  // one piece of string body: plain byte, short escape or \u escape
  task automatic push_token();
    int          pick;
    logic [7:0]  b;
    logic [15:0] cp;
    pick = $urandom_range(99);
    if (pick < 55) begin
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
      push_byte(b, 1'b0);
    end else if (pick < 75) begin
      push_byte(CH_BSLASH, 1'b0);
      push_byte(ESC_LETTERS[$urandom_range(7)], 1'b0);
    end else begin
      if ($urandom_range(9) == 0) cp = CP_EDGES[$urandom_range(5)];
      else begin
        case ($urandom_range(2))
          0: cp = 16'($urandom_range(16'h007f));
          1: cp = 16'($urandom_range(16'h07ff, 16'h0080));
          default: cp = 16'($urandom_range(16'hffff, 16'h0800));
        endcase
      end
      push_byte(CH_BSLASH, 1'b0);
      push_byte(CH_U, 1'b0);
      push_hex(cp[15:12]);
      push_hex(cp[11:8]);
      push_hex(cp[7:4]);
      push_hex(cp[3:0]);
    end
  endtask

  // mostly well-formed strings, some broken or left open
  task automatic push_string();
    int         pick;
    int         n_digits;
    logic [7:0] b;
    logic       ok;
    pick = $urandom_range(99);
    if (pick < 8) begin
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
      push_byte(b, 1'b1);
      push_noise($urandom_range(2));
    end else begin
      push_byte(CH_QUOTE, 1'b1);
      repeat ($urandom_range(1, 8)) push_token();
      if (pick < 75) begin
        push_byte(CH_QUOTE, 1'b0);
        if ($urandom_range(3) == 0) push_noise($urandom_range(1, 2));
      end else if (pick < 83) begin
        // escape letter outside the legal set
        push_byte(CH_BSLASH, 1'b0);
        do begin
          b = 8'($urandom_range(255));
          ok = (b != CH_U);
          foreach (ESC_LETTERS[i]) if (b == ESC_LETTERS[i]) ok = 1'b0;
        end while (!ok);
        push_byte(b, 1'b0);
        push_noise($urandom_range(2));
      end else if (pick < 91) begin
        // non-hex character somewhere in a \u escape
        push_byte(CH_BSLASH, 1'b0);
        push_byte(CH_U, 1'b0);
        n_digits = $urandom_range(3);
        repeat (n_digits) push_hex(4'($urandom_range(15)));
        do b = 8'($urandom_range(255));
        while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66));
        push_byte(b, 1'b0);
        push_noise($urandom_range(2));
      end
      // otherwise left open: the next start abandons it
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) push_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

    // three idling phases over the random part
    while (sent_items < ITEMS) begin
      if (sent_items >= 2 * ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end else if (sent_items >= ITEMS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct <= 10;
      end
      push_string();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input bytes in %0d strings, %0d results checked,",
             sent_items, strings_sent, checked);
    $display("with stalls on both sides, a long output hold-off and error recovery");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
